### src/fgsa_pkg.sv
package fgsa_pkg;

   localparam int GroupCount = 64;
   localparam int CityIndexBits = 3;
   localparam int IdxW = $clog2(GroupCount);
   localparam int CsrIdxW = 2;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW = $clog2(QueueDepth);
   localparam logic [7:0] CityBaseReset = 8'd230;

   typedef enum logic [1:0] {
      CSR_CITY_A = 2'd0,
      CSR_CITY_B = 2'd1,
      CSR_MONTH  = 2'd2,
      CSR_BASE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic            keep;
      logic [IdxW-1:0] idx;
      logic [31:0]     revenue;
      logic            last_row;
   } work_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_FLUSH,
      ST_SCAN,
      ST_EMIT,
      ST_CLEAR
   } back_state_type;

endpackage

### src/fgsa_if.sv
interface fgsa_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  cust_city;
   logic [7:0]  supp_city;
   logic [7:0]  year_month;
   logic [31:0] revenue;
   logic        last_row;
   modport source (output valid, cust_city, supp_city, year_month, revenue, last_row,
                   input ready);
   modport sink (input valid, cust_city, supp_city, year_month, revenue, last_row,
                 output ready);
endinterface

interface fgsa_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  group_cust_city;
   logic [7:0]  group_supp_city;
   logic [63:0] revenue_sum;
   logic        last_group;
   modport source (output valid, group_cust_city, group_supp_city, revenue_sum, last_group,
                   input ready);
   modport sink (input valid, group_cust_city, group_supp_city, revenue_sum, last_group,
                 output ready);
endinterface

### src/fgsa_front.sv
module fgsa_front (
   input  logic                   clock,
   input  logic                   reset,
   fgsa_req_if.sink               req,
   input  logic [7:0]             city_a,
   input  logic [7:0]             city_b,
   input  logic [7:0]             month,
   input  logic [7:0]             base,
   output logic                   q_valid,
   input  logic                   q_ready,
   output fgsa_pkg::work_type     q_word
);

   fgsa_pkg::work_type mem_ff [fgsa_pkg::QueueDepth];
   logic [fgsa_pkg::QueuePtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [fgsa_pkg::QueuePtrW:0]   cnt_ff, cnt_in;
   fgsa_pkg::work_type w;
   logic [7:0] cp, sp;
   logic push, pop;

   always_comb begin
      cp = req.cust_city - base;
      sp = req.supp_city - base;
      w.keep = (req.cust_city == city_a || req.cust_city == city_b)
         && (req.supp_city == city_a || req.supp_city == city_b)
         && (req.year_month == month);
      w.idx = fgsa_pkg::IdxW'({cp[fgsa_pkg::CityIndexBits-1:0],
                               sp[fgsa_pkg::CityIndexBits-1:0]});
      w.revenue = req.revenue;
      w.last_row = req.last_row;
   end

   assign req.ready = cnt_ff != (fgsa_pkg::QueuePtrW+1)'(fgsa_pkg::QueueDepth);
   assign push = req.valid && req.ready;
   assign q_valid = cnt_ff != '0;
   assign pop = q_valid && q_ready;
   assign q_word = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (fgsa_pkg::QueuePtrW+1)'(push) - (fgsa_pkg::QueuePtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= w;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (fgsa_pkg::QueuePtrW+1)'(fgsa_pkg::QueueDepth))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("count mismatch");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> !q_valid)
      else $error("empty queue valid");

endmodule

### src/fgsa_back.sv
module fgsa_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  fgsa_pkg::work_type   q_word,
   input  logic [7:0]           base,
   fgsa_rsp_if.source           rsp
);

   localparam int N = fgsa_pkg::GroupCount;
   localparam int IW = fgsa_pkg::IdxW;

   logic [63:0] sums_ff [N];
   logic [63:0] rdata_ff;
   logic [IW-1:0] rd_addr;
   logic [N-1:0] valid_ff, valid_in;
   logic [N-1:0] taken_ff, taken_in;
   fgsa_pkg::back_state_type st_ff, st_in;
   logic [IW:0] scan_ff, scan_in;
   logic [IW-1:0] best_ff, best_in;
   logic best_ok_ff, best_ok_in;
   logic [63:0] best_sum_ff, best_sum_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [IW:0] left_ff, left_in;
   logic cmp_ok_ff, cmp_ok_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic pend_ff, pend_in;
   logic pend_fwd_ff, pend_fwd_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic [31:0] pend_rev_ff, pend_rev_in;
   logic [63:0] wsum_ff, new_sum;
   logic [7:0] occ_c, occ_s;
   logic acc, cand;

   // An accepted row reads its group sum at the accepting edge and writes the
   // new sum at the next edge; a row that hits the group still being written
   // takes the freshly written sum instead of the stale read.
   assign rd_addr = (st_ff == fgsa_pkg::ST_ACCUM) ? q_word.idx : scan_ff[IW-1:0];
   assign new_sum = (pend_fwd_ff ? wsum_ff : rdata_ff) + 64'(pend_rev_ff);
   assign acc = st_ff == fgsa_pkg::ST_ACCUM && q_valid;
   assign q_ready = st_ff == fgsa_pkg::ST_ACCUM;
   assign pend_in = acc && q_word.keep;
   assign pend_idx_in = q_word.idx;
   assign pend_rev_in = q_word.revenue;
   assign pend_fwd_in = pend_ff && pend_idx_ff == q_word.idx;
   assign cmp_ok_in = st_ff == fgsa_pkg::ST_SCAN && !scan_ff[IW];
   assign cmp_idx_in = scan_ff[IW-1:0];
   assign cand = cmp_ok_ff && valid_ff[cmp_idx_ff] && !taken_ff[cmp_idx_ff]
      && (!best_ok_ff || rdata_ff > best_sum_ff);
   assign occ_c = 8'(best_ff >> fgsa_pkg::CityIndexBits);
   assign occ_s = 8'(best_ff & IW'((1 << fgsa_pkg::CityIndexBits) - 1));

   always_comb begin
      st_in = st_ff;
      scan_in = scan_ff;
      best_in = best_ff;
      best_ok_in = best_ok_ff;
      best_sum_in = best_sum_ff;
      valid_in = valid_ff;
      taken_in = taken_ff;
      clr_in = clr_ff;
      left_in = left_ff;
      case (st_ff)
         fgsa_pkg::ST_ACCUM: begin
            if (acc) begin
               if (q_word.keep) begin
                  valid_in[q_word.idx] = 1'b1;
               end
               if (q_word.last_row) begin
                  st_in = fgsa_pkg::ST_FLUSH;
               end
            end
         end
         fgsa_pkg::ST_FLUSH: begin
            st_in = fgsa_pkg::ST_SCAN;
            scan_in = '0;
            best_ok_in = 1'b0;
            taken_in = '0;
         end
         fgsa_pkg::ST_SCAN: begin
            if (!scan_ff[IW]) begin
               scan_in = scan_ff + 1'b1;
            end
            if (cand) begin
               best_in = cmp_idx_ff;
               best_sum_in = rdata_ff;
               best_ok_in = 1'b1;
            end
            if (cmp_ok_ff && cmp_idx_ff == IW'(N - 1)) begin
               if (best_ok_in) begin
                  st_in = fgsa_pkg::ST_EMIT;
                  taken_in[best_in] = 1'b1;
                  left_in = (IW+1)'($countones(valid_ff & ~taken_ff)) - 1'b1;
               end else begin
                  st_in = fgsa_pkg::ST_CLEAR;
                  clr_in = '0;
               end
            end
         end
         fgsa_pkg::ST_EMIT: begin
            if (rsp.ready) begin
               scan_in = '0;
               best_ok_in = 1'b0;
               if (left_ff == '0) begin
                  st_in = fgsa_pkg::ST_CLEAR;
                  clr_in = '0;
               end else begin
                  st_in = fgsa_pkg::ST_SCAN;
               end
            end
         end
         fgsa_pkg::ST_CLEAR: begin
            valid_in = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IW'(N - 1)) begin
               st_in = fgsa_pkg::ST_ACCUM;
            end
         end
         default: st_in = fgsa_pkg::ST_ACCUM;
      endcase
   end

   assign rsp.valid = st_ff == fgsa_pkg::ST_EMIT;
   assign rsp.group_cust_city = base + occ_c;
   assign rsp.group_supp_city = base + occ_s;
   assign rsp.revenue_sum = best_sum_ff;
   assign rsp.last_group = left_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= fgsa_pkg::ST_CLEAR;
         valid_ff <= '0;
         taken_ff <= '0;
         clr_ff <= '0;
         left_ff <= '0;
         best_ok_ff <= 1'b0;
         scan_ff <= '0;
         cmp_ok_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         valid_ff <= valid_in;
         taken_ff <= taken_in;
         clr_ff <= clr_in;
         left_ff <= left_in;
         best_ok_ff <= best_ok_in;
         scan_ff <= scan_in;
         cmp_ok_ff <= cmp_ok_in;
         pend_ff <= pend_in;
      end
      best_ff <= best_in;
      best_sum_ff <= best_sum_in;
      cmp_idx_ff <= cmp_idx_in;
      pend_idx_ff <= pend_idx_in;
      pend_rev_ff <= pend_rev_in;
      pend_fwd_ff <= pend_fwd_in;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= sums_ff[rd_addr];
      if (pend_ff) begin
         sums_ff[pend_idx_ff] <= new_sum;
         wsum_ff <= new_sum;
      end else if (st_ff == fgsa_pkg::ST_CLEAR) begin
         sums_ff[clr_ff] <= 64'd0;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(best_ff))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      st_ff == fgsa_pkg::ST_EMIT |-> taken_ff[best_ff] && valid_ff[best_ff])
      else $error("emitted group not occupied");
   assert property (@(posedge clock) disable iff (reset)
      st_ff != fgsa_pkg::ST_ACCUM |-> !q_ready)
      else $error("accepted work while draining");
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> st_ff == fgsa_pkg::ST_ACCUM || st_ff == fgsa_pkg::ST_FLUSH)
      else $error("table write outside accumulation");

endmodule

### src/filtered_group_sum_aggregator_top.sv
// Filtered group-by-sum aggregator.
// Rows enter on the req channel (valid/ready); each accepted word holds
// cust_city, supp_city, year_month, revenue and last_row. A row that passes
// the city and month filter adds its revenue into one of 64 group sums.
// The csr port writes four registers (city A, city B, month, base); the user
// must write them only while idle, as the block does not enforce it. The front
// classifies rows into a four-word queue; the back accumulates one row per
// cycle except while draining, so steady throughput is then one row per cycle.
// On a last row the back passes a flush state for the final table write, then
// walks the table once per result, each a scan of all 64 entries and an emit
// state; a clearing pass then zeroes the table. With no occupied group nothing
// is sent and the table is cleared after one scan. Results leave on the rsp
// channel in descending sum order, ties by ascending group index, the final
// one carrying last_group. A stalled rsp receiver holds the current result;
// rows then back up into the queue and req ready falls once it is full. After
// reset the table is cleared before the back takes rows.
module filtered_group_sum_aggregator_top (
   input  logic        clock,
   input  logic        reset,
   fgsa_req_if.sink    req,
   fgsa_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0] city_a_ff, city_b_ff, month_ff, base_ff;
   logic q_valid, q_ready;
   fgsa_pkg::work_type q_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         city_a_ff <= '0;
         city_b_ff <= '0;
         month_ff <= '0;
         base_ff <= fgsa_pkg::CityBaseReset;
      end else if (csr_we) begin
         case (fgsa_pkg::csr_index_type'(csr_index))
            fgsa_pkg::CSR_CITY_A: city_a_ff <= csr_wdata;
            fgsa_pkg::CSR_CITY_B: city_b_ff <= csr_wdata;
            fgsa_pkg::CSR_MONTH:  month_ff <= csr_wdata;
            fgsa_pkg::CSR_BASE:   base_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   fgsa_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .city_a(city_a_ff), .city_b(city_b_ff), .month(month_ff), .base(base_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
   );

   fgsa_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
      .base(base_ff), .rsp(rsp)
   );

endmodule
